// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the attribute tokenizer.
// Stand-alone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset disable.
`define GAT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication.
`define GAT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `GAT_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define GAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `GAT_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== design/gat_pkg.sv =====
// Types, character codes and the known attribute name table of the tokenizer.
// No dependencies; imported by every design module.
package gat_pkg;

    localparam int NAME_COUNT    = 11;
    localparam int NAME_MAX_LEN  = 17;
    localparam int KEY_NAME_BITS = NAME_MAX_LEN * 8;
    localparam int KEY_ID_W      = 4;
    localparam int FIELD_W       = 12;
    localparam int NUMBER_W      = 32;

    localparam logic [KEY_ID_W-1:0] KEY_UNKNOWN = 4'd11;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // Names are right-justified in each entry: the first char sits highest.
    localparam logic [KEY_NAME_BITS-1:0] KEY_NAMES [NAME_COUNT] = '{
        "gene_id", {"transcript", "_id"}, {"gene", "_type"}, {"gene", "_status"},
        {"gene", "_name"}, {"transcript", "_type"}, {"transcript", "_status"},
        {"transcript", "_name"}, {"exon", "_number"}, "exon_id", "level"
    };

    localparam logic [4:0] KEY_LENS [NAME_COUNT] = '{
        5'd7, 5'd13, 5'd9, 5'd11, 5'd9, 5'd15, 5'd17, 5'd15, 5'd11, 5'd7, 5'd5
    };

    typedef enum logic [3:0] {
        PH_SEEK_KEY = 4'b0001,
        PH_IN_KEY   = 4'b0010,
        PH_SEEK_VAL = 4'b0100,
        PH_IN_VAL   = 4'b1000
    } gat_phase_t;

    typedef struct packed {
        logic                       pair_valid;
        logic [KEY_ID_W-1:0]        key_id;
        logic [FIELD_W-1:0]         value_offset;
        logic [FIELD_W-1:0]         value_length;
        logic signed [NUMBER_W-1:0] value_number;
        logic                       line_done;
    } gat_result_t;

    // Character i of known name n; zero past the end of the name.
    function automatic logic [7:0] key_char(input logic [3:0] n, input logic [4:0] i);
        int         base;
        logic [7:0] ch;
        base = int'(KEY_LENS[n]) - 1 - int'(i);
        if (base >= 0)
            ch = KEY_NAMES[n][base*8 +: 8];
        else
            ch = 8'd0;
        return ch;
    endfunction

endpackage

// ===== design/gtf_attribute_tokenizer_top.sv =====
// An input transfer passes through the input register and then the result register to its result.
// Throughput: one byte per cycle while results are taken; the per-byte state update (key compare and the
// multiply-add by ten on the number accumulator) sets the cycle.
// Bytes that end no pair and are not end of line produce no output transfer.
// Reset (rst_n, asynchronous, active low) empties both registers and returns the
// tokenizer to the start of a line.
// Top level of the GTF attribute tokenizer; depends on gat_pkg and gat_core.
module gtf_attribute_tokenizer_top
    import gat_pkg::*;
#(
    parameter int LINE_BYTES  = 4096,
    parameter int KEY_MAX_LEN = 17
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,   // end_of_line
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [3:0] key_id, [15:4] value_offset,
                                        // [27:16] value_length, [59:28] value_number,
                                        // [63:60] zero
    output logic        m_axis_tuser,   // [0] pair_valid
    output logic        m_axis_tlast    // line_done
);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_eol_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    gat_result_t out_res_reg;

    logic        advance;     // byte in the input register is consumed this cycle
    logic        in_take;
    logic        load_out;
    gat_result_t core_res;
    logic        core_res_valid;

    // A byte moves on whenever the result register is free or being drained,
    // so a new byte can enter every cycle as long as results are taken.
    // A result held by the receiver stalls the input register.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign load_out      = advance && core_res_valid;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = load_out ? 1'b1
                          : ((out_valid_reg && m_axis_tready) ? 1'b0 : out_valid_reg);

    gat_core #(
        .LINE_BYTES  (LINE_BYTES),
        .KEY_MAX_LEN (KEY_MAX_LEN)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .char_byte   (in_byte_reg),
        .end_of_line (in_eol_reg),
        .res         (core_res),
        .res_valid   (core_res_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eol_reg  <= s_axis_tlast;
        end
        if (load_out)
            out_res_reg <= core_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000,
                            out_res_reg.value_number,
                            out_res_reg.value_length,
                            out_res_reg.value_offset,
                            out_res_reg.key_id};
    assign m_axis_tuser  = out_res_reg.pair_valid;
    assign m_axis_tlast  = out_res_reg.line_done;

endmodule

// ===== design/gat_key_match.sv =====
// Key matcher: narrows the candidate mask by one key byte and resolves the key id.
// Depends on gat_pkg.
module gat_key_match
    import gat_pkg::*;
#(
    parameter int KEY_MAX_LEN = 17,
    localparam int KLEN_W = $clog2(KEY_MAX_LEN + 1)
)
(
    input  logic [7:0]            char_byte,
    input  logic [NAME_COUNT-1:0] mask_in,
    input  logic [KLEN_W-1:0]     len_in,
    output logic [NAME_COUNT-1:0] mask_out,
    output logic [KLEN_W-1:0]     len_out,
    output logic [KEY_ID_W-1:0]   key_id
);

    always_comb
    begin
        mask_out = mask_in;
        for (int n = 0; n < NAME_COUNT; n++)
        begin
            if (len_in >= KLEN_W'(KEY_LENS[n]) ||
                key_char(4'(n), len_in[4:0]) != char_byte)
                mask_out[n] = 1'b0;
        end
        // length saturates so an overlong key can never match
        len_out = (len_in < KLEN_W'(KEY_MAX_LEN)) ? len_in + 1'b1 : len_in;
    end

    // lowest-numbered surviving name of the exact length wins
    always_comb
    begin
        key_id = KEY_UNKNOWN;
        for (int n = NAME_COUNT - 1; n >= 0; n--)
        begin
            if (mask_in[n] && len_in == KLEN_W'(KEY_LENS[n]))
                key_id = KEY_ID_W'(n);
        end
    end

endmodule

// ===== design/gat_core.sv =====
// Tokenizer core: phase machine, key and number state, per-byte result.
// Depends on gat_pkg and gat_key_match.
module gat_core
    import gat_pkg::*;
#(
    parameter int LINE_BYTES  = 4096,
    parameter int KEY_MAX_LEN = 17
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  char_byte,
    input  logic        end_of_line,
    output gat_result_t res,
    output logic        res_valid
);

    localparam int POS_W  = $clog2(LINE_BYTES);
    localparam int EXT_W  = (POS_W > FIELD_W) ? POS_W : FIELD_W;
    localparam int KLEN_W = $clog2(KEY_MAX_LEN + 1);
    localparam logic [NUMBER_W-1:0] MAG_LIMIT = {1'b1, {(NUMBER_W-1){1'b0}}};

    gat_phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]      pos_reg, pos_next, pos_inc;
    logic [KLEN_W-1:0]     klen_reg, klen_next;
    logic [NAME_COUNT-1:0] mask_reg, mask_next;
    logic [POS_W-1:0]      vstart_reg, vstart_next;
    logic [NUMBER_W-1:0]   acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic                  ended_reg, ended_next;
    logic                  begun_reg, begun_next;

    logic key_restart, key_step, num_restart, num_step, emit;
    logic is_space, is_quote, is_semi, is_digit, is_white;

    logic [NAME_COUNT-1:0] mask_in, mask_upd;
    logic [KLEN_W-1:0]     klen_in, klen_upd;
    logic [KEY_ID_W-1:0]   key_id;

    logic [NUMBER_W-1:0]   acc_in, acc_upd;
    logic                  neg_in, neg_upd, ended_in, ended_upd, begun_in, begun_upd;
    logic [NUMBER_W+3:0]   mac;
    logic                  skip;

    logic [POS_W-1:0]      vstart_eff;
    logic [POS_W:0]        len_full;
    logic [EXT_W-1:0]      off_ext, len_ext;
    logic [NUMBER_W-1:0]   number;

    assign is_space = (char_byte == CH_SPACE);
    assign is_quote = (char_byte == CH_QUOTE);
    assign is_semi  = (char_byte == CH_SEMI);
    assign is_digit = (char_byte inside {[CH_ZERO:CH_NINE]});
    assign is_white = is_space || (char_byte inside {[CH_TAB:CH_CR]});

    // phase decode
    always_comb
    begin
        phase_next  = phase_reg;
        key_restart = 1'b0;
        key_step    = 1'b0;
        num_restart = 1'b0;
        num_step    = 1'b0;
        emit        = 1'b0;
        case (phase_reg)
            PH_SEEK_KEY:
            begin
                if (!is_space && !is_quote && !is_semi)
                begin
                    key_restart = 1'b1;
                    key_step    = 1'b1;
                    phase_next  = PH_IN_KEY;
                end
            end
            PH_IN_KEY:
            begin
                if (is_space)
                    phase_next = PH_SEEK_VAL;
                else
                    key_step = 1'b1;
            end
            PH_SEEK_VAL:
            begin
                if (!is_space && !is_quote)
                begin
                    num_restart = 1'b1;
                    if (is_semi)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_SEEK_KEY;
                    end
                    else
                    begin
                        num_step   = 1'b1;
                        phase_next = PH_IN_VAL;
                    end
                end
            end
            PH_IN_VAL:
            begin
                if (is_quote || is_semi)
                begin
                    emit       = 1'b1;
                    phase_next = PH_SEEK_KEY;
                end
                else
                    num_step = 1'b1;
            end
            default: phase_next = PH_SEEK_KEY;
        endcase
    end

    assign mask_in = key_restart ? {NAME_COUNT{1'b1}} : mask_reg;
    assign klen_in = key_restart ? '0 : klen_reg;

    gat_key_match #(
        .KEY_MAX_LEN (KEY_MAX_LEN)
    ) u_key_match (
        .char_byte (char_byte),
        .mask_in   (mask_in),
        .len_in    (klen_in),
        .mask_out  (mask_upd),
        .len_out   (klen_upd),
        .key_id    (key_id)
    );

    // atoi step: skip leading white space, optional sign, then digits
    assign acc_in   = num_restart ? '0 : acc_reg;
    assign neg_in   = num_restart ? 1'b0 : neg_reg;
    assign ended_in = num_restart ? 1'b0 : ended_reg;
    assign begun_in = num_restart ? 1'b0 : begun_reg;
    assign mac = {acc_in, 3'b000} + {2'b00, acc_in, 1'b0}
               + (NUMBER_W+4)'(char_byte[3:0]);

    always_comb
    begin
        acc_upd   = acc_in;
        neg_upd   = neg_in;
        ended_upd = ended_in;
        begun_upd = begun_in;
        skip      = 1'b0;
        if (!ended_in)
        begin
            if (!begun_in)
            begin
                if (is_white)
                    skip = 1'b1;
                else
                begin
                    begun_upd = 1'b1;
                    if (char_byte == CH_PLUS || char_byte == CH_MINUS)
                    begin
                        neg_upd = (char_byte == CH_MINUS);
                        skip    = 1'b1;
                    end
                end
            end
            if (!skip)
            begin
                if (is_digit)
                begin
                    if (!acc_in[NUMBER_W-1])
                        acc_upd = (mac > (NUMBER_W+4)'(MAG_LIMIT)) ? MAG_LIMIT
                                                                  : mac[NUMBER_W-1:0];
                end
                else
                    ended_upd = 1'b1;
            end
        end
    end

    assign pos_inc    = (pos_reg == POS_W'(LINE_BYTES - 1)) ? '0 : pos_reg + 1'b1;
    assign vstart_eff = num_restart ? pos_reg : vstart_reg;
    assign len_full   = (pos_reg >= vstart_eff)
                      ? {1'b0, pos_reg} - {1'b0, vstart_eff}
                      : {1'b0, pos_reg} + (POS_W+1)'(LINE_BYTES) - {1'b0, vstart_eff};
    assign off_ext    = EXT_W'(vstart_eff);
    assign len_ext    = EXT_W'(len_full[POS_W-1:0]);
    assign number     = neg_in ? (~acc_in + 1'b1)
                      : (acc_in[NUMBER_W-1] ? {1'b0, {(NUMBER_W-1){1'b1}}} : acc_in);

    always_comb
    begin
        res_valid = emit || end_of_line;
        res = '0;
        res.line_done = end_of_line;
        if (emit)
        begin
            res.pair_valid   = 1'b1;
            res.key_id       = key_id;
            res.value_offset = off_ext[FIELD_W-1:0];
            res.value_length = len_ext[FIELD_W-1:0];
            res.value_number = number;
        end
    end

    always_comb
    begin
        klen_next   = key_step ? klen_upd : klen_reg;
        mask_next   = key_step ? mask_upd : mask_reg;
        vstart_next = vstart_eff;
        acc_next    = num_step ? acc_upd   : acc_in;
        neg_next    = num_step ? neg_upd   : neg_in;
        ended_next  = num_step ? ended_upd : ended_in;
        begun_next  = num_step ? begun_upd : begun_in;
        pos_next    = pos_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SEEK_KEY;
            pos_reg    <= '0;
            klen_reg   <= '0;
            mask_reg   <= {NAME_COUNT{1'b1}};
            vstart_reg <= '0;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            ended_reg  <= 1'b0;
            begun_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (end_of_line)
            begin
                phase_reg  <= PH_SEEK_KEY;
                pos_reg    <= '0;
                klen_reg   <= '0;
                mask_reg   <= {NAME_COUNT{1'b1}};
                vstart_reg <= '0;
                acc_reg    <= '0;
                neg_reg    <= 1'b0;
                ended_reg  <= 1'b0;
                begun_reg  <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                klen_reg   <= klen_next;
                mask_reg   <= mask_next;
                vstart_reg <= vstart_next;
                acc_reg    <= acc_next;
                neg_reg    <= neg_next;
                ended_reg  <= ended_next;
                begun_reg  <= begun_next;
            end
        end
    end

endmodule

// ===== design/gat_checker.sv =====
// Port-level checker for the tokenizer top level, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module gat_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result holds
    `GAT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")

    // a transfer without a pair only reports end of line, with cleared fields
    `GAT_ASSERT_IMPL(a_nopair_eol, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && (m_axis_tdata == 64'd0), "non-pair result without end of line")

    // key id stays within the known names plus unknown
    `GAT_ASSERT_IMPL(a_key_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[3:0] <= 4'd11 && m_axis_tdata[63:60] == 4'd0, "key id out of range")

    // nothing comes out the cycle after reset releases
    `GAT_ASSERT_NEXT(a_no_early_out, clk, rst_n, !$past(rst_n), !m_axis_tvalid, "result without input after reset")

endmodule

bind gtf_attribute_tokenizer_top gat_checker u_gat_checker (.*);
